FILE: hdl/assert_macros.svh
// Assertion macros used by the event interest table controller.
// Each macro expands to one labeled concurrent assertion with a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define EIT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define EIT_NEVER(label, clk, rst, expr, msg) \
   `EIT_ASSERT(label, clk, rst, !(expr), msg)

`endif

FILE: hdl/eit_pkg.sv
// ---------------------------------------------------------------------------
// eit_pkg: shared definitions for the event interest table
// Field widths, operation and status codes, and the structs that travel
// between the controller and the row of table cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eit_pkg;

   localparam int WATCH_CAP_DEF = 16;
   localparam int FD_COUNT      = 64;

   localparam int CMD_W    = 2;
   localparam int FD_W     = 6;
   localparam int MASK_W   = 32;
   localparam int TAG_W    = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_MOD = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_BADFD = 2'd1;
   localparam logic [STATUS_W-1:0] STS_INVAL = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

   // Search state handed from one cell to the next.
   typedef struct packed {
      logic found;
      logic have_free;
   } probe_type;

   // Write-back command broadcast to every cell.
   typedef struct packed {
      logic write;
      logic clear;
   } wcmd_type;

endpackage

`default_nettype wire

FILE: hdl/eit_cell.sv
// ---------------------------------------------------------------------------
// eit_cell: one entry of the event interest table
// Holds one watch entry, checks it against the descriptor under search and
// passes the registered search state on to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eit_cell import eit_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [FD_W-1:0]   bus_fd,
   input  wire logic [MASK_W-1:0] bus_mask,
   input  wire logic [TAG_W-1:0]  bus_tag,
   input  wire wcmd_type          wcmd,
   input  wire logic [IDX_W-1:0]  wslot,
   input  wire probe_type         probe_in,
   input  wire logic [IDX_W-1:0]  hit_in,
   input  wire logic [IDX_W-1:0]  free_in,
   output probe_type              probe_out,
   output logic      [IDX_W-1:0]  hit_out,
   output logic      [IDX_W-1:0]  free_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic              used_ff, used_in;
   logic [FD_W-1:0]   fd_ff, fd_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   probe_type         probe_ff, probe_nx_in;
   logic [IDX_W-1:0]  hit_ff, hit_nx_in;
   logic [IDX_W-1:0]  free_ff, free_nx_in;
   logic              match;
   logic              selected;

   assign match    = used_ff && (fd_ff == bus_fd);
   assign selected = (wslot == MY_IDX);

   always_comb begin
      probe_nx_in.found     = probe_in.found | match;
      probe_nx_in.have_free = probe_in.have_free | !used_ff;
      hit_nx_in             = (!probe_in.found && match) ? MY_IDX : hit_in;
      free_nx_in            = (!probe_in.have_free && !used_ff) ? MY_IDX : free_in;

      used_in = used_ff;
      fd_in   = fd_ff;
      mask_in = mask_ff;
      tag_in  = tag_ff;
      if (selected && wcmd.write) begin
         used_in = 1'b1;
         fd_in   = bus_fd;
         mask_in = bus_mask;
         tag_in  = bus_tag;
      end else if (selected && wcmd.clear) begin
         used_in = 1'b0;
         fd_in   = '0;
         mask_in = '0;
         tag_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         fd_ff    <= '0;
         mask_ff  <= '0;
         tag_ff   <= '0;
         probe_ff <= '0;
      end else begin
         used_ff  <= used_in;
         fd_ff    <= fd_in;
         mask_ff  <= mask_in;
         tag_ff   <= tag_in;
         probe_ff <= probe_nx_in;
      end
      hit_ff  <= hit_nx_in;
      free_ff <= free_nx_in;
   end

   assign probe_out = probe_ff;
   assign hit_out   = hit_ff;
   assign free_out  = free_ff;

endmodule

`default_nettype wire

FILE: hdl/eit_ctrl.sv
// ---------------------------------------------------------------------------
// eit_ctrl: request sequencer for the event interest table
// Takes a request, runs the search down the cell row, decides the outcome,
// issues the write-back and holds the response until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module eit_ctrl import eit_pkg::*; #(
   parameter int WATCH_CAP = WATCH_CAP_DEF,
   parameter int IDX_W     = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic                req_handles_valid,
   input  wire logic [FD_W-1:0]     req_target_fd,
   input  wire logic [MASK_W-1:0]   req_event_mask,
   input  wire logic [TAG_W-1:0]    req_user_tag,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [SLOT_W-1:0]   rsp_slot_index,
   input  wire probe_type           end_probe,
   input  wire logic [IDX_W-1:0]    end_hit,
   input  wire logic [IDX_W-1:0]    end_free,
   output logic      [FD_W-1:0]     bus_fd,
   output logic      [MASK_W-1:0]   bus_mask,
   output logic      [TAG_W-1:0]    bus_tag,
   output wcmd_type                 wcmd,
   output logic      [IDX_W-1:0]    wslot
);

   localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(WATCH_CAP - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [FD_W-1:0]     fd_ff, fd_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   wcmd_type            wcmd_ff, wcmd_in;
   logic [IDX_W-1:0]    wslot_ff, wslot_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      fd_in        = fd_ff;
      mask_in      = mask_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      wcmd_in      = '0;
      wslot_in     = wslot_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               fd_in   = req_target_fd;
               mask_in = req_event_mask;
               tag_in  = req_user_tag;
               cnt_in  = '0;
               if (!req_handles_valid || (32'(req_target_fd) >= FD_COUNT)) begin
                  status_in    = STS_BADFD;
                  slot_in      = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in    = STS_OK;
            slot_in      = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
            if (end_probe.found) begin
               if (cmd_ff == CMD_DEL) begin
                  wcmd_in.clear = 1'b1;
                  wslot_in      = end_hit;
                  slot_in       = SLOT_W'(end_hit);
               end else if (cmd_ff inside {CMD_ADD, CMD_MOD}) begin
                  wcmd_in.write = 1'b1;
                  wslot_in      = end_hit;
                  slot_in       = SLOT_W'(end_hit);
               end else begin
                  status_in = STS_INVAL;
               end
            end else if (cmd_ff == CMD_DEL) begin
               status_in = STS_BADFD;
            end else if (!(cmd_ff inside {CMD_ADD, CMD_MOD})) begin
               status_in = STS_INVAL;
            end else if (!end_probe.have_free) begin
               status_in = STS_FULL;
            end else begin
               wcmd_in.write = 1'b1;
               wslot_in      = end_free;
               slot_in       = SLOT_W'(end_free);
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wcmd_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         wcmd_ff      <= wcmd_in;
      end
      cmd_ff    <= cmd_in;
      fd_ff     <= fd_in;
      mask_ff   <= mask_in;
      tag_ff    <= tag_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      wslot_ff  <= wslot_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot_index = slot_ff;
   assign bus_fd         = fd_ff;
   assign bus_mask       = mask_ff;
   assign bus_tag        = tag_ff;
   assign wcmd           = wcmd_ff;
   assign wslot          = wslot_ff;

   `EIT_NEVER(wcmd_exclusive, clock, reset, wcmd_ff.write && wcmd_ff.clear, "write and clear together")
   `EIT_ASSERT(wcmd_with_ok, clock, reset, (wcmd_ff.write || wcmd_ff.clear) |-> (rsp_valid_ff && (status_ff == STS_OK)), "write-back without an ok response")
   `EIT_ASSERT(wcmd_single, clock, reset, (wcmd_ff.write || wcmd_ff.clear) |=> !(wcmd_ff.write || wcmd_ff.clear), "write-back held for more than one cycle")
   `EIT_ASSERT(slot_zero_on_error, clock, reset, (rsp_valid_ff && (status_ff != STS_OK)) |-> (slot_ff == '0), "nonzero slot on an error response")
   `EIT_NEVER(ready_while_busy, clock, reset, req_ready && rsp_valid_ff, "request taken while a response is pending")

endmodule

`default_nettype wire

FILE: hdl/event_interest_table.sv
// ---------------------------------------------------------------------------
// event_interest_table: watch table for descriptor interest requests
// A request names add, delete or modify on one descriptor. The block searches
// its table for that descriptor, updates the entry or claims the lowest free
// slot, and returns a status and the slot touched.
//
// Both channels use valid and ready. One request is in flight at a time:
// req_ready is high only while the block is idle. A request with valid
// handles is searched through the row of WATCH_CAP cells, one cell per cycle;
// the block then decides the outcome and shows the response, and it takes
// the next request once that response has been taken and it is idle again.
// A request with invalid handles skips the search and answers in the cycle
// after it is accepted. The entry write happens in the first cycle the
// response is shown. If the receiver stalls, the response is held and no
// new request is accepted. Reset empties the table at once and drops any
// pending response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_interest_table import eit_pkg::*; #(
   parameter int WATCH_CAP = WATCH_CAP_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic                req_handles_valid,
   input  wire logic [FD_W-1:0]     req_target_fd,
   input  wire logic [MASK_W-1:0]   req_event_mask,
   input  wire logic [TAG_W-1:0]    req_user_tag,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [SLOT_W-1:0]   rsp_slot_index
);

   localparam int IDX_W = (WATCH_CAP > 1) ? $clog2(WATCH_CAP) : 1;

   probe_type          probe_chain [0:WATCH_CAP];
   logic [IDX_W-1:0]   hit_chain   [0:WATCH_CAP];
   logic [IDX_W-1:0]   free_chain  [0:WATCH_CAP];
   logic [FD_W-1:0]    bus_fd;
   logic [MASK_W-1:0]  bus_mask;
   logic [TAG_W-1:0]   bus_tag;
   wcmd_type           wcmd;
   logic [IDX_W-1:0]   wslot;

   assign probe_chain[0] = '0;
   assign hit_chain[0]   = '0;
   assign free_chain[0]  = '0;

   eit_ctrl #(
      .WATCH_CAP (WATCH_CAP),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_handles_valid (req_handles_valid),
      .req_target_fd     (req_target_fd),
      .req_event_mask    (req_event_mask),
      .req_user_tag      (req_user_tag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .end_probe         (probe_chain[WATCH_CAP]),
      .end_hit           (hit_chain[WATCH_CAP]),
      .end_free          (free_chain[WATCH_CAP]),
      .bus_fd            (bus_fd),
      .bus_mask          (bus_mask),
      .bus_tag           (bus_tag),
      .wcmd              (wcmd),
      .wslot             (wslot)
   );

   for (genvar i = 0; i < WATCH_CAP; i++) begin : g_cell
      eit_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bus_fd    (bus_fd),
         .bus_mask  (bus_mask),
         .bus_tag   (bus_tag),
         .wcmd      (wcmd),
         .wslot     (wslot),
         .probe_in  (probe_chain[i]),
         .hit_in    (hit_chain[i]),
         .free_in   (free_chain[i]),
         .probe_out (probe_chain[i+1]),
         .hit_out   (hit_chain[i+1]),
         .free_out  (free_chain[i+1])
      );
   end

endmodule

`default_nettype wire
